>>> rtl/pipc_pkg.sv
// Package for the PI position controller: field widths, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pipc_pkg;

  localparam int ANGLE_W   = 32;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_W    = 32;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int ERR_W   = ANGLE_W + 1;
  localparam int INTEG_W = 48;
  localparam int TERM_W  = 49;
  localparam int INNER_W = 50;
  localparam int NM_W    = 49;
  localparam int IP_W    = 50;
  localparam int SUM_W   = 50;
  localparam int PROD_W  = 2 * GAIN_W;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 32'd65536;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST     = 32'd0;
  localparam logic [LIMIT_W-1:0] WINDUP_LIMIT_RST = 15'd255;
  localparam logic [GAIN_W-1:0]  TICK_SECONDS_RST = 32'd4294967;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INT_GAIN,
    REG_WINDUP_LIMIT,
    REG_TICK_SECONDS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_INT_LO,
    MUL_INT_HI,
    MUL_PROP_LO,
    MUL_PROP_HI,
    MUL_ERR_TICK
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_TERM,
    ST_INNER,
    ST_ABS,
    ST_MUL_PL,
    ST_MUL_PH,
    ST_CMD,
    ST_CHECK,
    ST_MUL_ERR,
    ST_INCR,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    mul_sel_t mul_sel;
    logic     rnd_en;
    logic     term_en;
    logic     inner_en;
    logic     abs_en;
    logic     phi_en;
    logic     ip_en;
    logic     drive_en;
    logic     incr_en;
    logic     acc_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic win_ok;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/pipc_if.sv
// Channel interfaces of the PI position controller: input, result and
// configuration write channels. Depends on pipc_pkg.
`default_nettype none

interface pipc_in_if import pipc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] target_angle;
  logic signed [ANGLE_W-1:0] measured_angle;
  modport source (output valid, target_angle, measured_angle, input ready);
  modport sink (input valid, target_angle, measured_angle, output ready);
endinterface

interface pipc_out_if import pipc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  modport source (output valid, drive_value, input ready);
  modport sink (input valid, drive_value, output ready);
endinterface

interface pipc_cfg_if import pipc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/pipc_ctrl.sv
// Sequencer of the PI position controller: steps the datapath through one
// control tick and owns the channel handshakes. Depends on pipc_pkg.
`default_nettype none

module pipc_ctrl import pipc_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  wire   out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_MUL_IL;
      ST_MUL_IL:  state_nxt = ST_MUL_IH;
      ST_MUL_IH:  state_nxt = ST_TERM;
      ST_TERM:    state_nxt = ST_INNER;
      ST_INNER:   state_nxt = ST_ABS;
      ST_ABS:     state_nxt = ST_MUL_PL;
      ST_MUL_PL:  state_nxt = ST_MUL_PH;
      ST_MUL_PH:  state_nxt = ST_CMD;
      ST_CMD:     state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = (!pass_r && stat.win_ok) ? ST_MUL_ERR : ST_DONE;
      ST_MUL_ERR: state_nxt = ST_INCR;
      ST_INCR:    state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_PREP;
      ST_DONE:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_INT_LO;
    in_ready      = (state_r == ST_IDLE);
    pass_nxt      = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) pass_nxt = 1'b0;
      end
      ST_PREP:    cmd.prep = 1'b1;
      ST_MUL_IL:  cmd.mul_sel = MUL_INT_LO;
      ST_MUL_IH: begin
        cmd.mul_sel = MUL_INT_HI;
        cmd.rnd_en  = 1'b1;
      end
      ST_TERM:    cmd.term_en = 1'b1;
      ST_INNER:   cmd.inner_en = 1'b1;
      ST_ABS:     cmd.abs_en = 1'b1;
      ST_MUL_PL:  cmd.mul_sel = MUL_PROP_LO;
      ST_MUL_PH: begin
        cmd.mul_sel = MUL_PROP_HI;
        cmd.phi_en  = 1'b1;
      end
      ST_CMD:     cmd.ip_en = 1'b1;
      ST_CHECK:   cmd.drive_en = 1'b1;
      ST_MUL_ERR: cmd.mul_sel = MUL_ERR_TICK;
      ST_INCR:    cmd.incr_en = 1'b1;
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        pass_nxt   = 1'b1;
      end
      ST_DONE:    cmd.out_load = !out_valid_r || out_ready;
      default:    cmd.out_load = 1'b0;
    endcase
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pipc_dp.sv
// Datapath of the PI position controller: configuration registers, held target,
// integral, one shared 32x32 multiplier and the rounding/saturation logic.
// Depends on pipc_pkg.
`default_nettype none

module pipc_dp import pipc_pkg::*; (
  input  wire                       clk,
  input  wire                       rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  wire signed [ANGLE_W-1:0]  target_angle,
  input  wire signed [ANGLE_W-1:0]  measured_angle,
  input  wire                       cfg_we,
  input  wire [CFG_IDX_W-1:0]       cfg_index,
  input  wire [CFG_DAT_W-1:0]       cfg_data,
  output logic signed [DRIVE_W-1:0] drive_value
);

  logic [GAIN_W-1:0]         prop_gain_r, int_gain_r, tick_r;
  logic [LIMIT_W-1:0]        windup_limit_r;
  logic [ANGLE_W-1:0]        held_target_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   err_r;
  logic [ANGLE_W-1:0]        err_mag_r;
  logic [INTEG_W-1:0]        im_r;
  logic                      integ_neg_r;
  logic [GAIN_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]         prod_r;
  logic [GAIN_W:0]           rnd_r;
  logic [TERM_W-1:0]         term_r;
  logic signed [INNER_W-1:0] inner_r, inner_nxt;
  logic [NM_W-1:0]           nm_r;
  logic                      cmd_neg_r;
  logic [GAIN_W-1:0]         p_hi_r, fp_r;
  logic [IP_W-1:0]           ip_r;
  logic [INTEG_W-1:0]        incr_r;
  logic signed [SUM_W-1:0]   sum;
  logic [IP_W:0]             rounded;
  logic [DRIVE_W-1:0]        mag16;
  logic [DRIVE_W-1:0]        drive_r, drive_nxt;
  logic [DRIVE_W-1:0]        out_drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      int_gain_r     <= INT_GAIN_RST;
      windup_limit_r <= WINDUP_LIMIT_RST;
      tick_r         <= TICK_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_INT_GAIN:     int_gain_r     <= cfg_data[GAIN_W-1:0];
        REG_WINDUP_LIMIT: windup_limit_r <= cfg_data[LIMIT_W-1:0];
        REG_TICK_SECONDS: tick_r         <= cfg_data[GAIN_W-1:0];
        default:          prop_gain_r    <= prop_gain_r;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_INT_LO: begin
        mul_a = int_gain_r;
        mul_b = im_r[31:0];
      end
      MUL_INT_HI: begin
        mul_a = int_gain_r;
        mul_b = {16'd0, im_r[INTEG_W-1:32]};
      end
      MUL_PROP_LO: begin
        mul_a = prop_gain_r;
        mul_b = nm_r[31:0];
      end
      MUL_PROP_HI: begin
        mul_a = prop_gain_r;
        mul_b = {15'd0, nm_r[NM_W-1:32]};
      end
      MUL_ERR_TICK: begin
        mul_a = err_mag_r;
        mul_b = tick_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // integral add with saturation to the 48-bit range
  always_comb begin
    if (err_r[ERR_W-1]) begin
      sum = SUM_W'(integ_r) - $signed({2'b00, incr_r});
    end else begin
      sum = SUM_W'(integ_r) + $signed({2'b00, incr_r});
    end
    if (sum[SUM_W-1:INTEG_W-1] == '0 || sum[SUM_W-1:INTEG_W-1] == '1) begin
      integ_nxt = sum[INTEG_W-1:0];
    end else if (sum[SUM_W-1]) begin
      integ_nxt = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_nxt = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (integ_neg_r) begin
      inner_nxt = INNER_W'(err_r) - $signed({1'b0, term_r});
    end else begin
      inner_nxt = INNER_W'(err_r) + $signed({1'b0, term_r});
    end
  end

  // round half away from zero, then saturate to the drive range
  always_comb begin
    rounded = {1'b0, ip_r} + (IP_W + 1)'(fp_r[GAIN_W-1]);
    if (cmd_neg_r) begin
      mag16     = (rounded > (IP_W + 1)'(32768)) ? 16'h8000 : rounded[DRIVE_W-1:0];
      drive_nxt = 16'd0 - mag16;
    end else begin
      mag16     = (rounded > (IP_W + 1)'(32767)) ? 16'h7FFF : rounded[DRIVE_W-1:0];
      drive_nxt = mag16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_target_r <= '0;
      integ_r       <= '0;
    end else if (cmd.load) begin
      if (target_angle != held_target_r) begin
        held_target_r <= target_angle;
        integ_r       <= '0;
      end
    end else if (cmd.acc_en) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= ERR_W'(target_angle) - ERR_W'(measured_angle);
    end
    if (cmd.prep) begin
      err_mag_r   <= err_r[ERR_W-1] ? ANGLE_W'(-err_r) : err_r[ANGLE_W-1:0];
      im_r        <= integ_r[INTEG_W-1] ? INTEG_W'(-integ_r) : integ_r;
      integ_neg_r <= integ_r[INTEG_W-1];
    end
    if (cmd.rnd_en) begin
      rnd_r <= (GAIN_W + 1)'(({1'b0, prod_r} + (PROD_W + 1)'(64'h8000_0000)) >> 32);
    end
    if (cmd.term_en) begin
      term_r <= {1'b0, prod_r[INTEG_W-1:0]} + TERM_W'(rnd_r);
    end
    if (cmd.inner_en) begin
      inner_r <= inner_nxt;
    end
    if (cmd.abs_en) begin
      nm_r      <= inner_r[INNER_W-1] ? NM_W'(-inner_r) : inner_r[NM_W-1:0];
      cmd_neg_r <= inner_r[INNER_W-1];
    end
    if (cmd.phi_en) begin
      p_hi_r <= prod_r[PROD_W-1:32];
      fp_r   <= prod_r[31:0];
    end
    if (cmd.ip_en) begin
      ip_r <= {1'b0, prod_r[IP_W-2:0]} + IP_W'(p_hi_r);
    end
    if (cmd.incr_en) begin
      incr_r <= INTEG_W'(({1'b0, prod_r} + (PROD_W + 1)'(16'h8000)) >> 16);
    end
    if (cmd.drive_en) begin
      drive_r <= drive_nxt;
    end
    if (cmd.out_load) begin
      out_drive_r <= drive_r;
    end
  end

  assign stat.win_ok = ip_r < IP_W'(windup_limit_r);
  assign drive_value = out_drive_r;

endmodule

`default_nettype wire

>>> rtl/pi_position_controller.sv
// Top level of the PI position controller with conditional-integration anti-windup.
// Joins the sequencer pipc_ctrl and the datapath pipc_dp; depends on pipc_pkg, pipc_if.
//
//   channel   dir  payload                              handshake
//   in_chan   in   target_angle, measured_angle (Q16.16) valid / ready
//   out_chan  out  drive_value (signed 16)               valid / ready
//   cfg_chan  in   index (2), data (32)                  valid / ready (always ready)
//
// One request evaluates the command once when the command is at or beyond the windup
// limit, and again after the integral is updated; each evaluation uses the single shared
// 32x32 multiplier four times.
// The result sits in an output register, so the next request is taken while it waits.
// Reset is synchronous: configuration returns to its defaults, target and integral clear.
`default_nettype none

module pi_position_controller import pipc_pkg::*; (
  input wire        clk,
  input wire        rst_n,
  pipc_in_if.sink   in_chan,
  pipc_out_if.source out_chan,
  pipc_cfg_if.sink  cfg_chan
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  pipc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pipc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .target_angle   (in_chan.target_angle),
    .measured_angle (in_chan.measured_angle),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .drive_value    (out_chan.drive_value)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign cfg_chan.ready = 1'b1;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_chan.ready))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.acc_en, cmd.out_load, cmd.prep}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for pi_position_controller: a scoreboard class predicts the
// drive for every accepted tick, and plain tasks drive the request and register channels.
// Depends on pipc_pkg, pipc_if and the controller RTL.

module testbench;
  import pipc_pkg::*;

  localparam longint INTEG_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;

  class drive_scoreboard;
    bit [63:0] kp, ki, lim, tsec;
    bit [31:0] held_tgt;
    longint integ;
    logic signed [15:0] pending[$];
    int errors, checked, integrated, clipped, drive_clamps;

    function new();
      kp = PROP_GAIN_RST;
      ki = INT_GAIN_RST;
      lim = WINDUP_LIMIT_RST;
      tsec = TICK_SECONDS_RST;
      held_tgt = '0;
      integ = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [31:0] value);
      case (idx)
        REG_PROP_GAIN: kp = value;
        REG_INT_GAIN: ki = value;
        REG_WINDUP_LIMIT: lim = value[LIMIT_W-1:0];
        REG_TICK_SECONDS: tsec = value;
        default: ;
      endcase
    endfunction

    function bit [63:0] mag(longint x);
      if (x < 0) return -x;
      return x;
    endfunction

    function bit eval_cmd(longint err, longint acc, output bit [63:0] ip,
                          output bit [63:0] fp);
      bit [63:0] am, lo, term, nm, p;
      longint inner;
      am = mag(acc);
      lo = ki * {32'd0, am[31:0]};
      term = ki * {32'd0, am[63:32]} + ((lo + 64'h8000_0000) >> 32);
      inner = (acc < 0) ? err - longint'(term) : err + longint'(term);
      nm = mag(inner);
      p = kp * {32'd0, nm[31:0]};
      ip = kp * {32'd0, nm[63:32]} + (p >> 32);
      fp = {32'd0, p[31:0]};
      return inner < 0;
    endfunction

    function void note_tick(bit [31:0] tgt, bit [31:0] meas);
      longint err, step, acc;
      bit [63:0] ip, fp, prod, r;
      bit neg;
      if (tgt != held_tgt) begin
        integ = 0;
        held_tgt = tgt;
      end
      err = longint'($signed(tgt)) - longint'($signed(meas));
      neg = eval_cmd(err, integ, ip, fp);
      if (ip < lim) begin
        integrated++;
        prod = mag(err) * tsec;
        step = longint'((prod + 64'h8000) >> 16);
        acc = (err < 0) ? integ - step : integ + step;
        if (acc > INTEG_TOP) begin
          acc = INTEG_TOP;
          clipped++;
        end else if (acc < INTEG_BOTTOM) begin
          acc = INTEG_BOTTOM;
          clipped++;
        end
        integ = acc;
        neg = eval_cmd(err, integ, ip, fp);
      end
      r = ip + (fp[31] ? 64'd1 : 64'd0);
      if (neg) begin
        if (r > 64'd32768) begin
          r = 64'd32768;
          drive_clamps++;
        end
        r = -r;
      end else if (r > 64'd32767) begin
        r = 64'd32767;
        drive_clamps++;
      end
      pending.push_back(r[15:0]);
    endfunction

    function void check_drive(logic signed [15:0] got);
      logic signed [15:0] want;
      checked++;
      if (pending.size() == 0) begin
        $error("drive_value: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("drive_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit idle_on = 1'b1;
  int settings = 1;
  drive_scoreboard sb = new();

  pipc_in_if in_chan();
  pipc_out_if out_chan();
  pipc_cfg_if cfg_chan();

  pi_position_controller i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) sb.check_drive(out_chan.drive_value);
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input bit [31:0] tgt, input bit [31:0] meas);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.target_angle <= tgt;
    in_chan.measured_angle <= meas;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_tick(tgt, meas);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input bit [31:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(input bit [31:0] kp, input bit [31:0] ki,
                            input bit [14:0] lim, input bit [31:0] ts);
    wait_drained();
    put_reg(REG_PROP_GAIN, kp);
    put_reg(REG_INT_GAIN, ki);
    put_reg(REG_WINDUP_LIMIT, {17'd0, lim});
    put_reg(REG_TICK_SECONDS, ts);
    cfg_chan.valid <= 1'b0;
    settings++;
  endtask

  function automatic bit [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(32'h0000_4000, 32'h0004_0000);
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 255);
      4: return 32'hFFFF_FFFF;
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  function automatic bit [14:0] pick_limit();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 32767);
      1: return $urandom_range(1, 300);
      default: return 15'h7FFF;
    endcase
  endfunction

  function automatic bit [31:0] pick_tick();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return TICK_SECONDS_RST;
      2: return $urandom_range(1, 32'h0100_0000);
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic bit [31:0] near(bit [31:0] tgt);
    bit [31:0] delta;
    delta = $urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1);
    return $urandom_range(0, 1) ? tgt - delta : tgt + delta;
  endfunction

  task automatic run_random(input int count);
    int sent, len;
    bit [31:0] tgt;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_tick($urandom, $urandom);
        sent++;
      end else begin
        tgt = $urandom_range(0, 1) ? $urandom : $urandom & 32'h00FF_FFFF;
        if ($urandom_range(0, 1)) tgt = -tgt;
        len = $urandom_range(2, 12);
        repeat (len) begin
          send_tick(tgt, near(tgt));
          sent++;
        end
      end
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.target_angle <= '0;
    in_chan.measured_angle <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= REG_PROP_GAIN;
    cfg_chan.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h0000_8000);
    send_tick(32'h0000_0000, 32'h0000_7FFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'h8000_0000, 32'h8000_0000);
    send_tick(32'h0064_0000, 32'h0000_0000);
    send_tick(32'h0064_0000, 32'h0001_0000);
    send_tick(32'hFFFF_FFFF, 32'h0000_0000);
    send_tick(32'h00FF_0000, 32'h0000_0000);

    set_config(32'd0, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);

    set_config(32'd1, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF);
    repeat (3) send_tick(32'h0001_0000, 32'h0000_0000);
    repeat (2) send_tick(32'h0000_0000, 32'h4000_0000);

    set_config(32'h0001_0000, 32'h0001_0000, 15'd10, 32'h8000_0000);
    send_tick(32'h000A_0000, 32'h0000_0000);
    send_tick(32'h000A_0000, 32'h0001_0000);
    send_tick(32'h000A_0000, 32'h0001_0000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(pick_gain(), 32'd0, 15'd0, 32'd0);
        1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF);
        default: set_config(pick_gain(), pick_gain(), pick_limit(), pick_tick());
      endcase
      if (ph == 7) idle_on = 1'b0;
      run_random(110);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("drive_value: %0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Summary: %0d drive results checked over %0d register settings.",
             sb.checked, settings);
    $display("Summary: %0d ticks integrated, %0d integral clamps, %0d drive clamps.",
             sb.integrated, sb.clipped, sb.drive_clamps);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> pi_position_controller.f
rtl/pipc_pkg.sv
rtl/pipc_if.sv
rtl/pipc_ctrl.sv
rtl/pipc_dp.sv
rtl/pi_position_controller.sv
tb/testbench.sv
